/* hw/rtl/mexp_pkg.sv */
// Package for the modular exponentiation block: constants, types and the base reduction function.
// Used by mexp_mulmod and modular_exponentiation; depends on nothing else.
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int unsigned BaseWidth = 32;
  localparam int unsigned ExpBits = 63;
  localparam int unsigned ResWidth = 30;
  localparam int unsigned ProdWidth = 2 * ResWidth;
  localparam int unsigned QuotWidth = ResWidth + 1;

  localparam int unsigned InTdataWidth = ((BaseWidth + ExpBits + 7) / 8) * 8;
  localparam int unsigned OutTdataWidth = ((ResWidth + 7) / 8) * 8;

  localparam logic [63:0] PrimeModWide = 64'd1000000007;
  localparam logic [ResWidth-1:0] PrimeMod = PrimeModWide[ResWidth-1:0];

  // Barrett constant floor(2^60 / P) for a 30-bit modulus.
  localparam logic [63:0] BarrettMuWide = (64'd1 << ProdWidth) / PrimeModWide;
  localparam logic [QuotWidth-1:0] BarrettMu = BarrettMuWide[QuotWidth-1:0];

  localparam logic [BaseWidth-1:0] PrimeMod1x = PrimeModWide[BaseWidth-1:0];
  localparam logic [63:0] PrimeMod2xWide = PrimeModWide * 64'd2;
  localparam logic [63:0] PrimeMod3xWide = PrimeModWide * 64'd3;
  localparam logic [63:0] PrimeMod4xWide = PrimeModWide * 64'd4;
  localparam logic [BaseWidth-1:0] PrimeMod2x = PrimeMod2xWide[BaseWidth-1:0];
  localparam logic [BaseWidth-1:0] PrimeMod3x = PrimeMod3xWide[BaseWidth-1:0];
  localparam logic [BaseWidth-1:0] PrimeMod4x = PrimeMod4xWide[BaseWidth-1:0];

  typedef enum logic [1:0] {
    StIdle,
    StSquare,
    StMult,
    StWait
  } state_e;

  typedef enum logic {
    TagSquare,
    TagAcc
  } tag_e;

  typedef struct packed {
    logic                valid;
    tag_e                tag;
    logic [ResWidth-1:0] a;
    logic [ResWidth-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                valid;
    tag_e                tag;
    logic [ResWidth-1:0] value;
  } mul_rsp_t;

  // A 32-bit word is below 5P, so one of five candidates is the residue.
  function automatic logic [ResWidth-1:0] reduce_base(input logic [BaseWidth-1:0] b);
    logic [BaseWidth-1:0] r;
    if (b >= PrimeMod4x) begin
      r = b - PrimeMod4x;
    end else if (b >= PrimeMod3x) begin
      r = b - PrimeMod3x;
    end else if (b >= PrimeMod2x) begin
      r = b - PrimeMod2x;
    end else if (b >= PrimeMod1x) begin
      r = b - PrimeMod1x;
    end else begin
      r = b;
    end
    return r[ResWidth-1:0];
  endfunction

endpackage

/* hw/rtl/mexp_mulmod.sv */
// Pipelined modular multiplier: a * b mod P with Barrett reduction in four register stages.
// Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_mulmod (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mexp_pkg::mul_req_t  req_i,
  output mexp_pkg::mul_rsp_t  rsp_o,
  output logic                busy_o
);

  import mexp_pkg::*;

  logic [3:0] valid_d, valid_q;
  tag_e       tag1_q, tag2_q, tag3_q, tag4_q;

  logic [ProdWidth-1:0]   prod_d, prod_q;
  logic [2*QuotWidth-1:0] quot_wide;
  logic [QuotWidth-1:0]   quot_d, quot_q;
  logic [BaseWidth-1:0]   xlo2_q, xlo3_q;
  logic [QuotWidth+ResWidth-1:0] qp_wide;
  logic [BaseWidth-1:0]   qp_d, qp_q;
  logic [BaseWidth-1:0]   rem_d, rem_q;
  logic [BaseWidth-1:0]   fixed;

  assign valid_d = {valid_q[2:0], req_i.valid};

  assign prod_d    = {{ResWidth{1'b0}}, req_i.a} * {{ResWidth{1'b0}}, req_i.b};
  assign quot_wide = {{QuotWidth{1'b0}}, prod_q[ProdWidth-1:ResWidth-1]} *
                     {{QuotWidth{1'b0}}, BarrettMu};
  assign quot_d    = quot_wide[2*QuotWidth-1:QuotWidth];
  assign qp_wide   = {{ResWidth{1'b0}}, quot_q} * {{QuotWidth{1'b0}}, PrimeMod};
  assign qp_d      = qp_wide[BaseWidth-1:0];
  assign rem_d     = xlo3_q - qp_q;

  // The Barrett remainder is below 3P, so one subtraction of 2P or of P completes it.
  always_comb begin
    if (rem_q >= PrimeMod2x) begin
      fixed = rem_q - PrimeMod2x;
    end else if (rem_q >= PrimeMod1x) begin
      fixed = rem_q - PrimeMod1x;
    end else begin
      fixed = rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q <= req_i.tag;
    prod_q <= prod_d;
    tag2_q <= tag1_q;
    quot_q <= quot_d;
    xlo2_q <= prod_q[BaseWidth-1:0];
    tag3_q <= tag2_q;
    qp_q   <= qp_d;
    xlo3_q <= xlo2_q;
    tag4_q <= tag3_q;
    rem_q  <= rem_d;
  end

  assign rsp_o.valid = valid_q[3];
  assign rsp_o.tag   = tag4_q;
  assign rsp_o.value = fixed[ResWidth-1:0];
  assign busy_o      = |valid_q;

endmodule

/* hw/rtl/modular_exponentiation.sv */
// Top level of the modular exponentiation block: stream ports, sequencer and result register.
// Depends on mexp_pkg and mexp_mulmod.
`timescale 1ns / 1ps

// The block computes base^exponent mod 1000000007 for each input word.
// The input channel carries the base and a 63-bit exponent; the output
// channel returns one 30-bit residue per input word, in order.
// The base is reduced modulo the prime when the word is accepted. The
// sequencer then scans the exponent from its lowest bit up, issuing a
// squaring and, for a set bit, a multiply into the accumulator, both on
// one shared four-stage pipelined modular multiplier. For each exponent
// bit the sequencer then waits until the multiplier is empty, so the
// multiplier latency sets the pace; scanning stops after the highest set
// bit, and the time a word takes grows with that position and with the
// number of set bits.
// The input is not ready while a word is in work. The result sits in an
// output register, so a new word is accepted while the last result still
// waits; a stalled receiver holds the block only when a further result is
// finished. Reset empties the pipeline and the output register.
module modular_exponentiation (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: base (32 bits), exponent (63 bits), one zero pad bit.
  input  logic [mexp_pkg::InTdataWidth-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from bit 0: power_result (30 bits), two zero pad bits.
  output logic [mexp_pkg::OutTdataWidth-1:0]   m_axis_tdata
);

  import mexp_pkg::*;

  state_e state_d, state_q;

  logic [ResWidth-1:0] sq_d, sq_q;
  logic [ResWidth-1:0] acc_d, acc_q;
  logic [ExpBits-1:0]  exp_d, exp_q;
  logic                out_valid_d, out_valid_q;
  logic [ResWidth-1:0] out_data_d, out_data_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  logic     mul_busy;

  logic in_fire;
  logic exp_zero;
  logic out_free;
  logic finish;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign exp_zero = (exp_q == '0);
  assign out_free = !out_valid_q || m_axis_tready;

  mexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp),
    .busy_o (mul_busy)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          state_d = StSquare;
        end
      end
      StSquare: begin
        if (exp_zero) begin
          if (out_free) begin
            state_d = StIdle;
          end
        end else if (exp_q[0]) begin
          state_d = StMult;
        end else begin
          state_d = StWait;
        end
      end
      StMult: begin
        state_d = StWait;
      end
      StWait: begin
        if (!mul_busy) begin
          state_d = StSquare;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    finish        = 1'b0;
    mul_req.valid = 1'b0;
    mul_req.tag   = TagSquare;
    mul_req.a     = sq_q;
    mul_req.b     = sq_q;
    unique case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
      end
      StSquare: begin
        mul_req.valid = !exp_zero;
        finish        = exp_zero && out_free;
      end
      StMult: begin
        mul_req.valid = 1'b1;
        mul_req.tag   = TagAcc;
        mul_req.a     = acc_q;
      end
      StWait: begin
        mul_req.valid = 1'b0;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    sq_d  = sq_q;
    acc_d = acc_q;
    exp_d = exp_q;
    if (in_fire) begin
      sq_d  = reduce_base(s_axis_tdata[BaseWidth-1:0]);
      acc_d = ResWidth'(1);
      exp_d = s_axis_tdata[BaseWidth+ExpBits-1:BaseWidth];
    end else begin
      if (state_q == StSquare && !exp_zero) begin
        exp_d = exp_q >> 1;
      end
      if (mul_rsp.valid) begin
        if (mul_rsp.tag == TagAcc) begin
          acc_d = mul_rsp.value;
        end else begin
          sq_d = mul_rsp.value;
        end
      end
    end
  end

  assign out_valid_d = finish || (out_valid_q && !m_axis_tready);
  assign out_data_d  = finish ? acc_q : out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q       <= sq_d;
    acc_q      <= acc_d;
    exp_q      <= exp_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataWidth - ResWidth){1'b0}}, out_data_q};

endmodule
